// ----- rtl/setl_pkg.sv -----
// Package for the sorted event time list: types, codes, constants and the key function.
// Used by setl_cell, sorted_event_time_list_top and setl_chk; it depends on nothing.
package setl_pkg;

  localparam int CAPACITY_DEF     = 8;
  localparam int MINUTES_PER_HOUR = 60;

  localparam int KIND_W   = 2;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int TAG_W    = 32;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int KEY_W    = 11;  // 31*60+63 fits

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_READ_ALT = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_SLOT = 2'd2
  } status_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // What a cell tells its neighbors about itself
  typedef struct packed {
    logic occ;  // holds an entry
    logic le;   // holds an entry whose key is at or below the new key
    logic gt;   // holds an entry whose key is above the new key
  } cell_stat_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic               del_en;
    logic [SLOT_W-1:0]  idx;
    logic [KEY_W-1:0]   key;
    entry_t             ent;
  } cell_op_t;

  function automatic logic [KEY_W-1:0] time_key(input logic [HOUR_W-1:0] hour,
                                                input logic [MINUTE_W-1:0] minute);
    time_key = KEY_W'(hour) * KEY_W'(MINUTES_PER_HOUR) + KEY_W'(minute);
  endfunction

endpackage

// ----- rtl/setl_cell.sv -----
// One position of the sorted list: holds an entry and its occupied bit.
// Shifts up from the left neighbor on insert, down from the right one on delete. Uses setl_pkg.
module setl_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  setl_pkg::cell_op_t    op,
  input  setl_pkg::cell_stat_t  left_stat,
  input  setl_pkg::entry_t      left_ent,
  input  setl_pkg::cell_stat_t  right_stat,
  input  setl_pkg::entry_t      right_ent,
  output setl_pkg::cell_stat_t  stat,
  output setl_pkg::entry_t      ent,
  output logic                  new_here
);

  setl_pkg::entry_t ent_r, ent_nxt;
  logic             occ_r, occ_nxt;
  logic             gt;
  logic             at_or_after_idx;

  assign gt              = occ_r && (setl_pkg::time_key(ent_r.hour, ent_r.minute) > op.key);
  assign stat.occ        = occ_r;
  assign stat.gt         = gt;
  assign stat.le         = occ_r && !gt;
  assign ent             = ent_r;
  assign new_here        = left_stat.le && !(occ_r && !gt);
  assign at_or_after_idx = (IDX >= int'(op.idx));

  always_comb begin
    ent_nxt = ent_r;
    occ_nxt = occ_r;
    if (op.ins_en) begin
      if (left_stat.gt) begin
        ent_nxt = left_ent;
      end else if (new_here) begin
        ent_nxt = op.ent;
      end
      occ_nxt = occ_r | left_stat.occ;
    end else if (op.del_en && at_or_after_idx) begin
      // close the gap: take the right neighbor
      ent_nxt = right_ent;
      occ_nxt = right_stat.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- rtl/sorted_event_time_list_top.sv -----
// Top level of the sorted event time list: a chain of setl_cell, the entry count,
// the operation decode and the result register. Uses setl_pkg and setl_cell.
//
// channel | dir | tdata (low bit first)                       | tuser
// in_     | in  | hour 5, minute 6, tag 32, slot_index 3        | kind 2
// out_    | out | slot 3, hour 5, minute 6, tag 32, count 4     | status 2
//
// Every accepted beat is applied to the cell chain at once; its result sits in the output register
// on the next cycle, so one beat per cycle is sustained while results are taken.
// All cells compare their key to the new one and shift at once; the read mux picks one cell.
// rst_n (synchronous) empties the list and drops any pending result.
// A stalled result holds; in_tready stays high as long as the result is taken that cycle.
module sorted_event_time_list_top #(
  parameter int CAPACITY = setl_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [setl_pkg::IN_TDATA_W-1:0]    in_tdata,   // hour, minute, tag, slot_index
  input  logic [setl_pkg::KIND_W-1:0]        in_tuser,   // kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [setl_pkg::OUT_TDATA_W-1:0]   out_tdata,  // slot, hour, minute, tag, count
  output logic [setl_pkg::STATUS_W-1:0]      out_tuser   // status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int XW = (CW > setl_pkg::COUNT_W) ? CW : setl_pkg::COUNT_W;
  localparam int RN = (CAPACITY < 8) ? CAPACITY : 8;

  // input fields
  logic [setl_pkg::HOUR_W-1:0]   in_hour;
  logic [setl_pkg::MINUTE_W-1:0] in_minute;
  logic [setl_pkg::TAG_W-1:0]    in_tag;
  logic [setl_pkg::SLOT_W-1:0]   in_slot;
  setl_pkg::kind_t               in_kind;

  assign in_hour   = in_tdata[4:0];
  assign in_minute = in_tdata[10:5];
  assign in_tag    = in_tdata[42:11];
  assign in_slot   = in_tdata[45:43];
  assign in_kind   = setl_pkg::kind_t'(in_tuser);

  logic accept;
  logic is_ins, is_del;
  logic full, bad_slot;
  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;

  setl_pkg::cell_op_t   op;
  setl_pkg::cell_stat_t stat_w [CAPACITY];
  setl_pkg::entry_t     ent_w  [CAPACITY];
  logic [CAPACITY-1:0]  new_w;
  setl_pkg::cell_stat_t edge_left, edge_right;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    unique case (in_kind)
      setl_pkg::KIND_INSERT: is_ins = 1'b1;
      setl_pkg::KIND_DELETE: is_del = 1'b1;
      default:               ;
    endcase
  end

  assign full     = (count_r == CW'(CAPACITY));
  assign bad_slot = (XW'(in_slot) >= XW'(count_r));

  assign op.ins_en     = accept && is_ins && !full;
  assign op.del_en     = accept && is_del && !bad_slot;
  assign op.idx        = in_slot;
  assign op.key        = setl_pkg::time_key(in_hour, in_minute);
  assign op.ent.hour   = in_hour;
  assign op.ent.minute = in_minute;
  assign op.ent.tag    = in_tag;

  // chain boundaries: a full-and-lower entry on the left, an empty cell on the right
  assign edge_left  = '{occ: 1'b1, le: 1'b1, gt: 1'b0};
  assign edge_right = '{occ: 1'b0, le: 1'b0, gt: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    setl_pkg::cell_stat_t ls, rs;
    setl_pkg::entry_t     le_ent, re_ent;
    if (i == 0) begin : g_first
      assign ls     = edge_left;
      assign le_ent = '0;
    end else begin : g_mid_l
      assign ls     = stat_w[i-1];
      assign le_ent = ent_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rs     = edge_right;
      assign re_ent = '0;
    end else begin : g_mid_r
      assign rs     = stat_w[i+1];
      assign re_ent = ent_w[i+1];
    end
    setl_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .left_stat  (ls),
      .left_ent   (le_ent),
      .right_stat (rs),
      .right_ent  (re_ent),
      .stat       (stat_w[i]),
      .ent        (ent_w[i]),
      .new_here   (new_w[i])
    );
  end

  // insert position: the one cell that takes the new entry
  logic [PW-1:0] ins_pos;
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (new_w[i]) begin
        ins_pos = ins_pos | PW'(i);
      end
    end
  end

  setl_pkg::entry_t rd_ent;
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < RN; i++) begin
      if (in_slot == setl_pkg::SLOT_W'(i)) begin
        rd_ent = ent_w[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (op.del_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  logic [setl_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;
  setl_pkg::status_t                   out_status_r, out_status_nxt;
  logic [XW-1:0]                       pos_x, cnt_x;
  logic [setl_pkg::SLOT_W-1:0]         res_slot;
  setl_pkg::entry_t                    res_ent;

  assign pos_x = XW'(ins_pos);
  assign cnt_x = XW'(count_nxt);

  always_comb begin
    out_status_nxt = setl_pkg::STATUS_OK;
    res_slot       = in_slot;
    res_ent        = '0;
    if (is_ins) begin
      if (full) begin
        out_status_nxt = setl_pkg::STATUS_FULL;
        res_slot       = '0;
      end else begin
        res_slot = pos_x[setl_pkg::SLOT_W-1:0];
      end
    end else if (bad_slot) begin
      out_status_nxt = setl_pkg::STATUS_BAD_SLOT;
    end else begin
      res_ent = rd_ent;
    end
    out_data_nxt = {6'd0, cnt_x[setl_pkg::COUNT_W-1:0], res_ent.tag, res_ent.minute,
                    res_ent.hour, res_slot};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- rtl/setl_chk.sv -----
// Port-level checks for sorted_event_time_list_top, bound to it below.
// Uses setl_pkg for field widths and status codes.
module setl_chk #(
  parameter int CAPACITY = setl_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [setl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [setl_pkg::STATUS_W-1:0]      out_tuser
);

  localparam logic [setl_pkg::COUNT_W-1:0] CAP_MASKED = setl_pkg::COUNT_W'(CAPACITY);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a full report carries the capacity as count and an empty entry
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == setl_pkg::STATUS_FULL |->
      out_tdata[49:46] == CAP_MASKED && out_tdata[45:0] == '0)
    else $error("full report with wrong count or fields");

  // a bad slot report carries no entry
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == setl_pkg::STATUS_BAD_SLOT |-> out_tdata[45:3] == '0)
    else $error("bad slot report with entry data");

  // an accepted beat yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat gave no result");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_event_time_list_top setl_chk #(.CAPACITY(CAPACITY)) u_setl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- dv/sorted_event_time_list_top_tb.sv -----
// Self-checking testbench for sorted_event_time_list_top: directed, fill/drain, random and
// backpressure beats checked against an in-bench model of the sorted list.
// Depends on setl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module sorted_event_time_list_top_tb;
  import setl_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [TAG_W-1:0]    tag;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // Model of the list contents
  logic [HOUR_W-1:0]   held_hour [LIST_DEPTH];
  logic [MINUTE_W-1:0] held_minute [LIST_DEPTH];
  logic [TAG_W-1:0]    held_tag [LIST_DEPTH];
  int                  held_n = 0;

  list_result_t pending_results [$];
  int           err_count = 0;
  int           out_beats = 0;
  int           burst_left = 0;
  bit           no_gaps = 1'b0;
  int unsigned  rx_cycle = 0;
  int           rx_hold_left = 0;
  bit           rx_hold_request = 1'b0;

  sorted_event_time_list_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic int time_of(input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] m);
    return int'(h) * MINUTES_PER_HOUR + int'(m);
  endfunction

  // Apply one operation to the model list and return the result it must produce
  function automatic list_result_t list_apply(input kind_t k, input logic [HOUR_W-1:0] h,
                                              input logic [MINUTE_W-1:0] m,
                                              input logic [TAG_W-1:0] t,
                                              input logic [SLOT_W-1:0] s);
    list_result_t r;
    int pos;
    int key;
    r = '0;
    if (k == KIND_INSERT) begin
      if (held_n >= LIST_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        key = time_of(h, m);
        pos = held_n;
        // equal keys stay ahead of the new entry
        while (pos > 0 && time_of(held_hour[pos-1], held_minute[pos-1]) > key) pos--;
        for (int j = held_n; j > pos; j--) begin
          held_hour[j]   = held_hour[j-1];
          held_minute[j] = held_minute[j-1];
          held_tag[j]    = held_tag[j-1];
        end
        held_hour[pos]   = h;
        held_minute[pos] = m;
        held_tag[pos]    = t;
        held_n++;
        r.status = STATUS_OK;
        r.slot   = SLOT_W'(pos);
      end
    end else if (int'(s) >= held_n) begin
      r.status = STATUS_BAD_SLOT;
      r.slot   = s;
    end else begin
      r.status = STATUS_OK;
      r.slot   = s;
      r.hour   = held_hour[s];
      r.minute = held_minute[s];
      r.tag    = held_tag[s];
      if (k == KIND_DELETE) begin
        for (int j = int'(s); j + 1 < held_n; j++) begin
          held_hour[j]   = held_hour[j+1];
          held_minute[j] = held_minute[j+1];
          held_tag[j]    = held_tag[j+1];
        end
        held_n--;
      end
    end
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  // Offer one beat in bursts with random gaps; return once it is taken
  task automatic send_beat(input kind_t k, input logic [HOUR_W-1:0] h,
                           input logic [MINUTE_W-1:0] m, input logic [TAG_W-1:0] t,
                           input logic [SLOT_W-1:0] s);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {2'b00, s, t, m, h};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(list_apply(k, h, m, t, s));
  endtask

  function automatic logic [HOUR_W-1:0] rand_hour();
    return HOUR_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 23)
                                                : $urandom_range(0, 31));
  endfunction

  function automatic logic [MINUTE_W-1:0] rand_minute();
    return MINUTE_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 59)
                                                  : $urandom_range(0, 63));
  endfunction

  // Mostly occupied slots, sometimes any slot
  function automatic logic [SLOT_W-1:0] rand_slot();
    if (held_n > 0 && $urandom_range(0, 9) < 8) return SLOT_W'($urandom_range(0, held_n - 1));
    return SLOT_W'($urandom_range(0, 7));
  endfunction

  // One random operation, biased so the list keeps moving between empty and full
  task automatic send_random_op();
    int roll;
    int ins_pct;
    kind_t k;
    logic [HOUR_W-1:0] h;
    logic [MINUTE_W-1:0] m;
    roll    = $urandom_range(0, 99);
    ins_pct = (held_n <= 2) ? 60 : (held_n >= 7) ? 30 : 45;
    if (roll < ins_pct) k = KIND_INSERT;
    else if (roll < ins_pct + 30) k = KIND_DELETE;
    else k = ($urandom_range(0, 9) == 0) ? KIND_READ_ALT : KIND_READ;
    if ($urandom_range(0, 3) == 0) begin
      // small key pool to make ties common
      h = HOUR_W'($urandom_range(6, 7));
      m = MINUTE_W'($urandom_range(0, 1));
    end else begin
      h = rand_hour();
      m = rand_minute();
    end
    send_beat(k, h, m, $urandom, rand_slot());
  endtask

  task automatic test_directed();
    send_beat(KIND_READ, 0, 0, 0, 0);                    // read of empty list
    send_beat(KIND_DELETE, 31, 63, 32'hFFFF_FFFF, 7);    // delete on empty list
    send_beat(KIND_INSERT, 12, 30, 32'hA5A5_A5A5, 0);
    send_beat(KIND_INSERT, 0, 0, 32'h0000_0000, 7);
    send_beat(KIND_INSERT, 23, 59, 32'hFFFF_FFFF, 0);
    send_beat(KIND_INSERT, 31, 63, 32'h5A5A_5A5A, 5);    // out-of-range time
    send_beat(KIND_INSERT, 12, 30, 32'h0000_0001, 0);    // tie goes after
    send_beat(KIND_INSERT, 1, 0, 32'h0000_0002, 0);
    send_beat(KIND_INSERT, 0, 60, 32'h0000_0003, 0);     // same key as 1:00
    send_beat(KIND_INSERT, 23, 59, 32'h8000_0000, 0);    // list now full
    send_beat(KIND_INSERT, 5, 5, 32'h1234_5678, 3);      // rejected: full
    send_beat(KIND_READ_ALT, 0, 0, 0, 7);
    for (int i = 0; i < 3; i++) send_beat(KIND_READ, 0, 0, 0, SLOT_W'(i * 3));
    send_beat(KIND_DELETE, 0, 0, 0, 0);                  // first
    send_beat(KIND_DELETE, 0, 0, 0, 6);                  // last
    send_beat(KIND_DELETE, 0, 0, 0, 2);                  // middle
    send_beat(KIND_READ, 0, 0, 0, 7);                    // beyond count
    send_beat(KIND_DELETE, 0, 0, 0, 5);                  // exactly at count
    send_beat(KIND_READ_ALT, 0, 0, 0, 6);
    send_beat(KIND_READ, 0, 0, 0, 4);
  endtask

  // Fill to full and drain to empty with different key orders
  task automatic test_fill_drain(input int rounds);
    logic [HOUR_W-1:0] h;
    logic [MINUTE_W-1:0] m;
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i <= LIST_DEPTH; i++) begin
        case (r % 4)
          0: begin h = rand_hour(); m = rand_minute(); end
          1: begin h = 9; m = 15; end
          2: begin h = HOUR_W'(23 - 2 * i); m = MINUTE_W'(59 - i); end
          default: begin h = HOUR_W'(i); m = MINUTE_W'(i * 7); end
        endcase
        send_beat(KIND_INSERT, h, m, $urandom, SLOT_W'($urandom_range(0, 7)));
      end
      repeat (3) send_beat(KIND_READ, rand_hour(), rand_minute(), $urandom, rand_slot());
      while (held_n > 0) begin
        case ($urandom_range(0, 2))
          0: send_beat(KIND_DELETE, 0, 0, $urandom, 0);
          1: send_beat(KIND_DELETE, 0, 0, $urandom, SLOT_W'(held_n - 1));
          default: send_beat(KIND_DELETE, 0, 0, $urandom, rand_slot());
        endcase
      end
      send_beat(KIND_DELETE, 0, 0, $urandom, SLOT_W'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_random_mix(input int beats);
    repeat (beats) send_random_op();
  endtask

  // Hold the output off for a long stretch while beats keep coming
  task automatic test_backpressure(input int beats);
    no_gaps = 1'b1;
    burst_left = 0;
    rx_hold_request = 1'b1;
    repeat (beats) send_random_op();
    no_gaps = 1'b0;
  endtask

  // Receiver: pattern of its own plus one long hold on request
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_hold_request) begin
      rx_hold_left = 80;
      rx_hold_request = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 37) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // Compare every taken result with the oldest prediction
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.status = status_t'(out_tuser);
      got.slot   = out_tdata[2:0];
      got.hour   = out_tdata[7:3];
      got.minute = out_tdata[13:8];
      got.tag    = out_tdata[45:14];
      got.count  = out_tdata[49:46];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("out beat %0d: result with nothing pending: status=%0d slot=%0d count=%0d",
                   out_beats, got.status, got.slot, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("out beat %0d mismatch", out_beats);
            $display("  expected status=%0d slot=%0d hour=%0d minute=%0d tag=%h count=%0d",
                     want.status, want.slot, want.hour, want.minute, want.tag, want.count);
            $display("  actual   status=%0d slot=%0d hour=%0d minute=%0d tag=%h count=%0d",
                     got.status, got.slot, got.hour, got.minute, got.tag, got.count);
          end
        end
      end
      out_beats++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_drain(8);
    test_random_mix(500);
    test_backpressure(120);
    test_random_mix(150);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("sorted_event_time_list_top_tb: done, clean");
    end else begin
      $display("sorted_event_time_list_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("sorted_event_time_list_top_tb: done, errors");
    $finish;
  end

endmodule

// ----- sorted_event_time_list_top.f -----
rtl/setl_pkg.sv
rtl/setl_cell.sv
rtl/sorted_event_time_list_top.sv
rtl/setl_chk.sv
dv/sorted_event_time_list_top_tb.sv
